>>> rtl/core/finger_count_action_qualifier_top_assert.svh
// Assertion macros for the finger count action qualifier.
// Each macro expands to a concurrent assertion in simulation and to nothing
// when SYNTHESIS is defined. No dependencies.
`ifndef FINGER_COUNT_ACTION_QUALIFIER_TOP_ASSERT_SVH
`define FINGER_COUNT_ACTION_QUALIFIER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FCAQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fcaq assertion failed");

// next-cycle implication
`define FCAQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fcaq assertion failed");

`else

`define FCAQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons)

`define FCAQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/fcaq_pkg.sv
// Package for the finger count action qualifier.
// Action codes, finger count codes, register map and reset values. No dependencies.
package fcaq_pkg;

	typedef enum logic [2:0] {
		ACT_MOVE    = 3'd0,
		ACT_LEFT    = 3'd1,
		ACT_RIGHT   = 3'd2,
		ACT_DOUBLE  = 3'd3,
		ACT_DRAG    = 3'd4,
		ACT_RELEASE = 3'd5
	} action_t;

	localparam int NUM_CNT = 5;

	localparam logic [3:0] FC_LEFT  = 4'd2;
	localparam logic [3:0] FC_DRAG  = 4'd3;
	localparam logic [3:0] FC_RIGHT = 4'd4;

	localparam int SENS_W    = 7;
	localparam int HOLDOFF_W = 16;
	localparam int POS_W     = 16;
	localparam int CNT_W     = 8;

	localparam logic [SENS_W-1:0]    SENS_RESET    = 7'd5;
	localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 16'd500;

	// register select is paddr[2]
	localparam logic REG_SENS    = 1'b0;
	localparam logic REG_HOLDOFF = 1'b1;

	typedef logic [CNT_W-1:0] cnt_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		cnt_t r;
		r = (v == '1) ? v : v + cnt_t'(1);
		return r;
	endfunction

endpackage

>>> rtl/core/finger_count_action_qualifier_top.sv
// Finger count action qualifier, top level.
// Depends on fcaq_pkg and finger_count_action_qualifier_top_assert.svh.
//
// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid / s_axis_tready    tuser func, tdata fingers + cursor
// m_axis    out  m_axis_tvalid / m_axis_tready    tuser action, tdata press/pos/release
// apb       in   psel & penable & pwrite, pready  sensitivity @0x0, holdoff_ticks @0x4
//
// One transaction per cycle while the output does not stall; input register, then result register.
// Qualifier state updates as the item leaves the input register, so the next item
// sees it without bubbles. Tick transactions that produce no result are dropped there.
// Reset clears counters, holdoff timer, held button and restores register defaults.
// Output stall holds the input register; s_axis_tready falls only then.
`include "finger_count_action_qualifier_top_assert.svh"

module finger_count_action_qualifier_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [0:0]  s_axis_tuser,  // [0] func
	input  logic [39:0] s_axis_tdata,  // [3:0] finger_count, [19:4] cursor_x, [35:20] cursor_y
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [2:0]  m_axis_tuser,  // [2:0] action
	output logic [71:0] m_axis_tdata,  // [0] drag_press, [16:1] pos_x, [32:17] pos_y,
	                                   // [33] release_emitted, [49:34] release_x,
	                                   // [65:50] release_y
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PW = fcaq_pkg::POS_W;

	// configuration
	logic [fcaq_pkg::SENS_W-1:0]    sens_q;
	logic [fcaq_pkg::HOLDOFF_W-1:0] holdoff_q;
	logic                           cfg_wr;

	// input register
	logic          v_s1;
	logic          func_s1;
	logic [3:0]    fc_s1;
	logic [PW-1:0] x_s1;
	logic [PW-1:0] y_s1;
	logic          adv;

	// qualifier state
	fcaq_pkg::cnt_t                 cnt_q [fcaq_pkg::NUM_CNT];
	fcaq_pkg::cnt_t                 cnt_n [fcaq_pkg::NUM_CNT];
	logic [fcaq_pkg::HOLDOFF_W-1:0] hold_q, hold_n;
	logic                           held_q, held_n;
	logic [PW-1:0]                  ldx_q, ldx_n, ldy_q, ldy_n;

	// result
	logic              res_v;
	fcaq_pkg::action_t res_act;
	logic              res_press;
	logic [PW-1:0]     res_px, res_py;
	logic              rel_e;
	logic [PW-1:0]     rel_x, rel_y;

	// output register
	logic              out_v_q;
	fcaq_pkg::action_t act_q;
	logic              press_q;
	logic [PW-1:0]     px_q, py_q;
	logic              rel_e_q;
	logic [PW-1:0]     rel_x_q, rel_y_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q    <= fcaq_pkg::SENS_RESET;
			holdoff_q <= fcaq_pkg::HOLDOFF_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				fcaq_pkg::REG_SENS:    sens_q    <= pwdata[fcaq_pkg::SENS_W-1:0];
				fcaq_pkg::REG_HOLDOFF: holdoff_q <= pwdata[fcaq_pkg::HOLDOFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			fcaq_pkg::REG_SENS:    prdata = {{(32-fcaq_pkg::SENS_W){1'b0}}, sens_q};
			fcaq_pkg::REG_HOLDOFF: prdata = {{(32-fcaq_pkg::HOLDOFF_W){1'b0}}, holdoff_q};
			default:               prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	assign adv           = v_s1 & (~out_v_q | m_axis_tready);
	assign s_axis_tready = ~v_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_s1 <= s_axis_tuser[0];
			fc_s1   <= s_axis_tdata[3:0];
			x_s1    <= s_axis_tdata[19:4];
			y_s1    <= s_axis_tdata[35:20];
		end
	end

	// ---------------- qualifier ----------------
	always_comb begin
		logic              active;
		logic              do_move;
		fcaq_pkg::action_t idx;

		cnt_n     = cnt_q;
		hold_n    = hold_q;
		held_n    = held_q;
		ldx_n     = ldx_q;
		ldy_n     = ldy_q;
		res_v     = 1'b0;
		res_act   = fcaq_pkg::ACT_MOVE;
		res_press = 1'b0;
		res_px    = x_s1;
		res_py    = y_s1;
		rel_e     = 1'b0;
		rel_x     = '0;
		rel_y     = '0;
		do_move   = 1'b0;
		idx       = fcaq_pkg::ACT_DOUBLE;
		active    = (hold_q != '0);

		if (func_s1) begin
			if (active) begin
				hold_n = hold_q - 16'd1;
				if (hold_n == '0 && held_q) begin
					res_v   = 1'b1;
					res_act = fcaq_pkg::ACT_RELEASE;
					res_px  = ldx_q;
					res_py  = ldy_q;
				end
			end
		end else begin
			res_v = 1'b1;
			if (fc_s1 == fcaq_pkg::FC_DRAG) begin
				if (held_q || (!active &&
				    cnt_q[fcaq_pkg::ACT_DRAG] > {1'b0, sens_q})) begin
					hold_n    = holdoff_q;
					cnt_n     = '{default: '0};
					res_act   = fcaq_pkg::ACT_DRAG;
					res_press = ~held_q;
					held_n    = 1'b1;
					ldx_n     = x_s1;
					ldy_n     = y_s1;
				end else begin
					cnt_n[fcaq_pkg::ACT_DRAG] = fcaq_pkg::sat_inc(cnt_q[fcaq_pkg::ACT_DRAG]);
					do_move = 1'b1;
				end
			end else if (!active && fc_s1 >= fcaq_pkg::FC_LEFT) begin
				if (fc_s1 == fcaq_pkg::FC_LEFT)
					idx = fcaq_pkg::ACT_LEFT;
				else if (fc_s1 == fcaq_pkg::FC_RIGHT)
					idx = fcaq_pkg::ACT_RIGHT;
				if (cnt_q[idx] > {1'b0, sens_q}) begin
					hold_n  = holdoff_q;
					cnt_n   = '{default: '0};
					res_act = idx;
				end else begin
					cnt_n[idx] = fcaq_pkg::sat_inc(cnt_q[idx]);
					do_move = 1'b1;
				end
			end else begin
				do_move = 1'b1;
			end

			if (do_move) begin
				cnt_n[fcaq_pkg::ACT_MOVE] = fcaq_pkg::sat_inc(cnt_q[fcaq_pkg::ACT_MOVE]);
				if (cnt_n[fcaq_pkg::ACT_MOVE] > {sens_q, 1'b0})
					cnt_n = '{default: '0};
			end
		end

		// any non-drag result drops a held button at the last drag position
		if (res_v && res_act != fcaq_pkg::ACT_DRAG && held_q) begin
			rel_e  = 1'b1;
			rel_x  = ldx_q;
			rel_y  = ldy_q;
			held_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '{default: '0};
			hold_q <= '0;
			held_q <= 1'b0;
			ldx_q  <= '0;
			ldy_q  <= '0;
		end else if (adv) begin
			cnt_q  <= cnt_n;
			hold_q <= hold_n;
			held_q <= held_n;
			ldx_q  <= ldx_n;
			ldy_q  <= ldy_n;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= res_v;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_v) begin
			act_q   <= res_act;
			press_q <= res_press;
			px_q    <= res_px;
			py_q    <= res_py;
			rel_e_q <= rel_e;
			rel_x_q <= rel_x;
			rel_y_q <= rel_y;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = act_q;
	assign m_axis_tdata  = {6'd0, rel_y_q, rel_x_q, rel_e_q, py_q, px_q, press_q};

	// ---------------- checks ----------------
	`FCAQ_ASSERT_NEXT(a_tick_counts_down, clk, arst_n, adv && func_s1 && hold_q != '0, hold_q == $past(hold_q) - 16'd1)
	`FCAQ_ASSERT_NOW(a_release_only_flags, clk, arst_n, out_v_q && act_q == fcaq_pkg::ACT_RELEASE, rel_e_q)
	`FCAQ_ASSERT_NEXT(a_drag_holds_button, clk, arst_n, adv && res_v && res_act == fcaq_pkg::ACT_DRAG, held_q)
	`FCAQ_ASSERT_NEXT(a_stall_freezes_state, clk, arst_n, !adv, $stable(held_q) && $stable(hold_q))

endmodule
